// ----- hdl/resistance_band_step_duty_controller_top_macros.svh -----
// assertion macros for the resistance band step duty controller
// used by the back end; no other dependencies
`ifndef RESISTANCE_BAND_STEP_DUTY_CONTROLLER_TOP_MACROS_SVH
`define RESISTANCE_BAND_STEP_DUTY_CONTROLLER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// a implies b in the same cycle
`define RBSD_ASSERT_IMPL(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("rbsd assertion failed");
// a implies b in the next cycle
`define RBSD_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("rbsd assertion failed");
`else
`define RBSD_ASSERT_IMPL(lbl, clk, rstn, a, b)
`define RBSD_ASSERT_NEXT(lbl, clk, rstn, a, b)
`endif

`endif

// ----- hdl/rbsd_pkg.sv -----
// shared types and constants for the resistance band step duty controller
// no dependencies
package rbsd_pkg;

  // converter resolution and field widths
  localparam int ADC_BITS = 10;
  localparam int CODE_W   = 10;
  localparam int REF_W    = 16;
  localparam int LIM_W    = 16;
  localparam int STEP_W   = 7;
  localparam int DUTY_W   = 8;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 3;
  localparam int DEN_W    = ADC_BITS + 1;
  localparam int NUM_W    = CODE_W + REF_W;
  localparam int MEAS_W   = 26;
  localparam int CNT_W    = $clog2(NUM_W);
  localparam int Q_DEPTH  = 2;
  localparam int QPTR_W   = $clog2(Q_DEPTH);
  localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

  // reset values of the configuration registers
  localparam logic [REF_W-1:0]  SETPOINT_RST = 16'd5000;
  localparam logic [LIM_W-1:0]  FINE_LIM_RST = 16'd100;
  localparam logic [LIM_W-1:0]  MID_LIM_RST  = 16'd1000;
  localparam logic [STEP_W-1:0] FINE_STEP_RST   = 7'd1;
  localparam logic [STEP_W-1:0] MID_STEP_RST    = 7'd5;
  localparam logic [STEP_W-1:0] COARSE_STEP_RST = 7'd10;
  localparam logic [DUTY_W-1:0] DUTY_LIM_RST = 8'd100;
  localparam logic [REF_W-1:0]  REF_RST      = 16'd10000;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_SETPOINT    = 3'd0,
    REG_FINE_LIM    = 3'd1,
    REG_MID_LIM     = 3'd2,
    REG_FINE_STEP   = 3'd3,
    REG_MID_STEP    = 3'd4,
    REG_COARSE_STEP = 3'd5,
    REG_DUTY_LIM    = 3'd6,
    REG_REF         = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [REF_W-1:0]  setpoint;
    logic [LIM_W-1:0]  fine_lim;
    logic [LIM_W-1:0]  mid_lim;
    logic [STEP_W-1:0] fine_step;
    logic [STEP_W-1:0] mid_step;
    logic [STEP_W-1:0] coarse_step;
    logic [DUTY_W-1:0] duty_lim;
    logic [REF_W-1:0]  ref_ohms;
  } cfg_t;

  // one queued division job
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } q_item_t;

  // queue pop request from the back end
  typedef struct packed {
    logic pop;
  } q_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_BAND,
    ST_OUT
  } back_state_t;

endpackage

// ----- hdl/resistance_band_step_duty_controller_top.sv -----
// top level of the resistance band step duty controller
// depends on rbsd_pkg, rbsd_front, rbsd_queue and rbsd_back
//
// Each accepted converter word produces one result word. The front end masks the
// code, forms code*ref and the denominator, and drops the job into a two-entry
// queue; the back end pulls the job from the queue in its idle state, then runs a
// bit-serial restoring divider, one quotient bit per cycle, then a band select
// state and a duty update state. The back end works on one word at a time and
// takes the next job from the queue only once the last word has gone to the
// output register; a stalled result word holds the back end further. Register
// writes are taken at once.
module resistance_band_step_duty_controller_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rbsd_pkg::IDX_W-1:0]    cfg_index,
  input  logic [rbsd_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rbsd_pkg::CODE_W-1:0]   in_adc_code,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rbsd_pkg::DUTY_W-1:0]   out_duty,
  output logic [rbsd_pkg::MEAS_W-1:0]   out_measured_ohms,
  output logic                          out_raising
);
  import rbsd_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  q_item_t front_item;
  q_item_t q_head;
  q_ctl_t  qctl;
  logic    q_full;
  logic    q_valid;
  logic    push;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_SETPOINT:    cfg_nxt.setpoint    = cfg_wdata[REF_W-1:0];
        REG_FINE_LIM:    cfg_nxt.fine_lim    = cfg_wdata[LIM_W-1:0];
        REG_MID_LIM:     cfg_nxt.mid_lim     = cfg_wdata[LIM_W-1:0];
        REG_FINE_STEP:   cfg_nxt.fine_step   = cfg_wdata[STEP_W-1:0];
        REG_MID_STEP:    cfg_nxt.mid_step    = cfg_wdata[STEP_W-1:0];
        REG_COARSE_STEP: cfg_nxt.coarse_step = cfg_wdata[STEP_W-1:0];
        REG_DUTY_LIM:    cfg_nxt.duty_lim    = cfg_wdata[DUTY_W-1:0];
        REG_REF:         cfg_nxt.ref_ohms    = cfg_wdata[REF_W-1:0];
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint    <= SETPOINT_RST;
      cfg_r.fine_lim    <= FINE_LIM_RST;
      cfg_r.mid_lim     <= MID_LIM_RST;
      cfg_r.fine_step   <= FINE_STEP_RST;
      cfg_r.mid_step    <= MID_STEP_RST;
      cfg_r.coarse_step <= COARSE_STEP_RST;
      cfg_r.duty_lim    <= DUTY_LIM_RST;
      cfg_r.ref_ohms    <= REF_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input handshake
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  rbsd_front u_front (
    .in_adc_code (in_adc_code),
    .ref_ohms    (cfg_r.ref_ohms),
    .item        (front_item)
  );

  rbsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (qctl.pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  rbsd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head              (q_head),
    .qctl_out          (qctl),
    .q_valid           (q_valid),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_duty          (out_duty),
    .out_measured_ohms (out_measured_ohms),
    .out_raising       (out_raising)
  );

endmodule

// ----- hdl/rbsd_front.sv -----
// front end: masks the converter code, forms the divider numerator and denominator
// depends on rbsd_pkg
module rbsd_front (
  input  logic [rbsd_pkg::CODE_W-1:0] in_adc_code,
  input  logic [rbsd_pkg::REF_W-1:0]  ref_ohms,
  output rbsd_pkg::q_item_t           item
);
  import rbsd_pkg::*;

  localparam logic [CODE_W-1:0] CODE_MASK = CODE_W'((64'd1 << ADC_BITS) - 64'd1);
  localparam logic [DEN_W-1:0]  FULL      = DEN_W'(64'd1 << ADC_BITS);

  logic [CODE_W-1:0] code;

  // code * ref over (full scale - code)
  always_comb begin
    code      = in_adc_code & CODE_MASK;
    item.num  = NUM_W'(code) * NUM_W'(ref_ohms);
    item.den  = FULL - DEN_W'(code);
  end

endmodule

// ----- hdl/rbsd_queue.sv -----
// two-entry queue between front and back ends
// depends on rbsd_pkg
module rbsd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rbsd_pkg::q_item_t   push_item,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output rbsd_pkg::q_item_t   head
);
  import rbsd_pkg::*;

  q_item_t           mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  assign full  = (cnt_r == QCNT_W'(Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem[rd_ptr_r];

endmodule

// ----- hdl/rbsd_back.sv -----
// back end: bit-serial divider, band select, duty update and output register
// depends on rbsd_pkg and the assertion macro header
`include "resistance_band_step_duty_controller_top_macros.svh"
module rbsd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rbsd_pkg::cfg_t                cfg,
  input  rbsd_pkg::q_item_t             head,
  output rbsd_pkg::q_ctl_t              qctl_out,
  input  logic                          q_valid,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rbsd_pkg::DUTY_W-1:0]   out_duty,
  output logic [rbsd_pkg::MEAS_W-1:0]   out_measured_ohms,
  output logic                          out_raising
);
  import rbsd_pkg::*;

  back_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic              up_r, up_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DUTY_W-1:0] duty_level_r, duty_level_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DUTY_W-1:0] out_duty_r;
  logic [MEAS_W-1:0] out_meas_r;
  logic              out_raising_r;
  logic              load_out;

  logic [DEN_W:0]    rem_sh;
  logic              ge;
  logic [MEAS_W-1:0] meas;
  logic [MEAS_W-1:0] sp_ext;
  logic [MEAS_W-1:0] mag;
  logic              up_now;
  logic [DUTY_W:0]   sum;
  logic [DUTY_W-1:0] nd;

  // one restoring divide step
  always_comb begin
    rem_sh = {rem_r, num_r[NUM_W-1]};
    ge     = (rem_sh >= {1'b0, den_r});
  end

  // error magnitude against setpoint
  always_comb begin
    meas   = MEAS_W'(num_r);
    sp_ext = MEAS_W'(cfg.setpoint);
    up_now = (meas > sp_ext);
    mag    = up_now ? meas - sp_ext : sp_ext - meas;
  end

  // saturated duty update
  always_comb begin
    sum = '0;
    if (up_r) begin
      sum = {1'b0, duty_level_r} + (DUTY_W + 1)'(step_r);
    end else if ({1'b0, duty_level_r} > (DUTY_W + 1)'(step_r)) begin
      sum = {1'b0, duty_level_r} - (DUTY_W + 1)'(step_r);
    end
    nd = (sum > {1'b0, cfg.duty_lim}) ? cfg.duty_lim : sum[DUTY_W-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    rem_nxt        = rem_r;
    up_nxt         = up_r;
    step_nxt       = step_r;
    duty_level_nxt = duty_level_r;
    qctl_out.pop   = 1'b0;
    load_out       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          qctl_out.pop = 1'b1;
          num_nxt      = head.num;
          den_nxt      = head.den;
          rem_nxt      = '0;
          cnt_nxt      = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
        num_nxt = {num_r[NUM_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = ST_BAND;
        end
      end
      ST_BAND: begin
        up_nxt = up_now;
        priority if (mag < MEAS_W'(cfg.fine_lim)) begin
          step_nxt = cfg.fine_step;
        end else if (mag < MEAS_W'(cfg.mid_lim)) begin
          step_nxt = cfg.mid_step;
        end else begin
          step_nxt = cfg.coarse_step;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          load_out       = 1'b1;
          duty_level_nxt = nd;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output slot occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      duty_level_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      duty_level_r <= duty_level_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // datapath and output word
  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    up_r   <= up_nxt;
    step_r <= step_nxt;
    if (load_out) begin
      out_duty_r    <= nd;
      out_meas_r    <= MEAS_W'(num_r);
      out_raising_r <= up_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_duty          = out_duty_r;
  assign out_measured_ohms = out_meas_r;
  assign out_raising       = out_raising_r;

  // partial remainder stays below the divisor
  `RBSD_ASSERT_IMPL(a_rem_below_den, clk, rst_n, state_r == ST_DIV, rem_r < den_r)
  // a shown word carries the stored duty
  `RBSD_ASSERT_IMPL(a_out_duty_stored, clk, rst_n, out_valid_r, out_duty_r == duty_level_r)
  // a word is never loaded over one still waiting
  `RBSD_ASSERT_IMPL(a_no_overwrite, clk, rst_n, load_out && out_valid_r, !out_stall)
  // after loading, the sequencer is back to idle
  `RBSD_ASSERT_NEXT(a_load_to_idle, clk, rst_n, load_out, state_r == ST_IDLE)

endmodule
